FILE: sv/ide_pkg.sv
// ----------------------------------------------------------------------------
// ide_pkg: shared types and constants
// Payload structs, register indexes, error codes and calendar helpers.
// ----------------------------------------------------------------------------
package ide_pkg;

    localparam int unsigned MaxFractionDigits = 9;

    typedef struct packed {
        logic [7:0] text_char;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] epoch_value;
        logic [2:0]         error_code;
    } t_out_item;

    localparam logic [0:0] REG_OUTPUT_MODE     = 1'd0;
    localparam logic [0:0] REG_FRACTION_DIGITS = 1'd1;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_DATE     = 3'd1;
    localparam logic [2:0] ERR_RANGE    = 3'd2;
    localparam logic [2:0] ERR_MONTHEND = 3'd3;
    localparam logic [2:0] ERR_TIME     = 3'd4;
    localparam logic [2:0] ERR_ZONE     = 3'd5;
    localparam logic [2:0] ERR_UINT32   = 3'd6;

    // command from controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic step;
    } t_ide_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic done;
    } t_ide_sts;

    // month length, non-leap
    function automatic logic [4:0] month_len(input logic [3:0] m);
        case (m)
            4'd2:                      month_len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

    // days before month m, non-leap
    function automatic logic [8:0] days_before(input logic [3:0] m);
        case (m)
            4'd2:    days_before = 9'd31;
            4'd3:    days_before = 9'd59;
            4'd4:    days_before = 9'd90;
            4'd5:    days_before = 9'd120;
            4'd6:    days_before = 9'd151;
            4'd7:    days_before = 9'd181;
            4'd8:    days_before = 9'd212;
            4'd9:    days_before = 9'd243;
            4'd10:   days_before = 9'd273;
            4'd11:   days_before = 9'd304;
            4'd12:   days_before = 9'd334;
            default: days_before = 9'd0;
        endcase
    endfunction

    // powers of ten up to the max precision
    function automatic logic [29:0] pow10(input logic [3:0] n);
        case (n)
            4'd0:    pow10 = 30'd1;
            4'd1:    pow10 = 30'd10;
            4'd2:    pow10 = 30'd100;
            4'd3:    pow10 = 30'd1000;
            4'd4:    pow10 = 30'd10000;
            4'd5:    pow10 = 30'd100000;
            4'd6:    pow10 = 30'd1000000;
            4'd7:    pow10 = 30'd10000000;
            4'd8:    pow10 = 30'd100000000;
            default: pow10 = 30'd1000000000;
        endcase
    endfunction

endpackage

FILE: sv/ide_parse.sv
// ----------------------------------------------------------------------------
// ide_parse: character scanner
// Accumulates date, time, fraction and zone fields, one character per cycle in which i_step is high.
// ----------------------------------------------------------------------------
module ide_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_clear,
    input  logic [7:0]        i_char,
    input  logic [1:0]        i_mode,
    input  logic [3:0]        i_prec,
    output logic [5:0]        o_len,
    output logic [13:0]       o_year,
    output logic [6:0]        o_month,
    output logic [6:0]        o_day,
    output logic [18:0]       o_hms,
    output logic [29:0]       o_frac,
    output logic [3:0]        o_frac_cnt,
    output logic [18:0]       o_zone,
    output logic              o_zone_neg,
    output logic [2:0]        o_sticky,
    output logic              o_zone_open
);
    import ide_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD, PH_FRAC, PH_TZ_H1, PH_TZ_H2, PH_TZ_COLON, PH_TZ_M1, PH_TZ_M2, PH_DONE
    } t_phase;

    logic [5:0]  r_pos;
    logic [13:0] r_year;
    logic [6:0]  r_month, r_day;
    logic [18:0] r_hms, r_zone;
    logic [29:0] r_frac;
    logic [3:0]  r_fcnt, r_mint;
    logic        r_neg;
    logic [2:0]  r_sticky;
    t_phase      r_ph;

    logic [5:0]  n_pos;
    logic [13:0] n_year;
    logic [6:0]  n_month, n_day;
    logic [18:0] n_hms, n_zone;
    logic [29:0] n_frac;
    logic [3:0]  n_fcnt, n_mint;
    logic        n_neg;
    logic [2:0]  n_sticky;
    t_phase      n_ph;

    logic        dig;
    logic [3:0]  d;
    logic [16:0] w;

    assign dig = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign d   = dig ? 4'(i_char - 8'h30) : 4'd0;

    // time digit weight by position
    always_comb begin
        case (r_pos)
            6'd11:   w = 17'd36000;
            6'd12:   w = 17'd3600;
            6'd14:   w = 17'd600;
            6'd15:   w = 17'd60;
            6'd17:   w = 17'd10;
            6'd18:   w = 17'd1;
            default: w = 17'd0;
        endcase
    end

    // next-state parse logic
    always_comb begin
        n_pos = r_pos; n_year = r_year; n_month = r_month; n_day = r_day;
        n_hms = r_hms; n_zone = r_zone; n_frac = r_frac; n_fcnt = r_fcnt;
        n_mint = r_mint; n_neg = r_neg; n_sticky = r_sticky; n_ph = r_ph;
        if (r_pos < 6'd10) begin
            if (r_pos == 6'd4 || r_pos == 6'd7) begin
                if (i_char != 8'h2D) n_sticky[0] = 1'b1;
            end else begin
                if (!dig) n_sticky[0] = 1'b1;
                if (r_pos < 6'd4) n_year = 14'(r_year * 14'd10 + 14'(d));
                else if (r_pos < 6'd7) n_month = 7'(r_month * 7'd10 + 7'(d));
                else n_day = 7'(r_day * 7'd10 + 7'(d));
            end
        end else if (r_pos < 6'd19) begin
            if (r_pos == 6'd10) begin
                if (i_char != 8'h20 && i_char != 8'h54) n_sticky[1] = 1'b1;
            end else if (r_pos == 6'd13 || r_pos == 6'd16) begin
                if (i_char != 8'h3A) n_sticky[1] = 1'b1;
            end else begin
                if (!dig) n_sticky[1] = 1'b1;
                n_hms = 19'(r_hms + 19'(d) * 19'(w));
            end
        end else if (r_pos == 6'd19) begin
            if (i_mode >= 2'd2 && i_char == 8'h2E) n_ph = PH_FRAC;
            else if (i_char == 8'h2B || i_char == 8'h2D) begin
                n_neg = (i_char == 8'h2D); n_ph = PH_TZ_H1;
            end else n_ph = PH_DONE;
        end else begin
            case (r_ph)
                PH_FRAC: begin
                    if (dig) begin
                        if (r_fcnt < i_prec) begin
                            n_frac = 30'(r_frac * 30'd10 + 30'(d));
                            n_fcnt = r_fcnt + 4'd1;
                        end
                    end else if (i_char == 8'h2B || i_char == 8'h2D) begin
                        n_neg = (i_char == 8'h2D); n_ph = PH_TZ_H1;
                    end else n_ph = PH_DONE;
                end
                PH_TZ_H1: begin
                    if (dig) begin n_zone = 19'(d) * 19'd36000; n_ph = PH_TZ_H2; end
                    else begin n_sticky[2] = 1'b1; n_ph = PH_DONE; end
                end
                PH_TZ_H2: begin
                    if (dig) begin n_zone = 19'(r_zone + 19'(d) * 19'd3600); n_ph = PH_TZ_COLON; end
                    else begin n_sticky[2] = 1'b1; n_ph = PH_DONE; end
                end
                PH_TZ_COLON: begin
                    if (i_char == 8'h3A) n_ph = PH_TZ_M1;
                    else if (dig) begin n_mint = d; n_ph = PH_TZ_M2; end
                    else n_ph = PH_DONE;
                end
                PH_TZ_M1: begin
                    if (dig) begin n_mint = d; n_ph = PH_TZ_M2; end
                    else n_ph = PH_DONE;
                end
                PH_TZ_M2: begin
                    if (dig) n_zone = 19'(r_zone + 19'(r_mint) * 19'd600 + 19'(d) * 19'd60);
                    n_ph = PH_DONE;
                end
                default: n_ph = r_ph;
            endcase
        end
        if (r_pos < 6'd63) n_pos = r_pos + 6'd1;
    end

    // field registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos <= '0; r_year <= '0; r_month <= '0; r_day <= '0; r_hms <= '0;
            r_zone <= '0; r_frac <= '0; r_fcnt <= '0; r_mint <= '0; r_neg <= 1'b0;
            r_sticky <= '0; r_ph <= PH_HEAD;
        end else if (i_step) begin
            r_pos <= n_pos; r_year <= n_year; r_month <= n_month; r_day <= n_day;
            r_hms <= n_hms; r_zone <= n_zone; r_frac <= n_frac; r_fcnt <= n_fcnt;
            r_mint <= n_mint; r_neg <= n_neg; r_sticky <= n_sticky; r_ph <= n_ph;
        end
    end

    // the final character is folded in through the next-state view
    assign o_len       = n_pos;
    assign o_year      = n_year;
    assign o_month     = n_month;
    assign o_day       = n_day;
    assign o_hms       = n_hms;
    assign o_frac      = n_frac;
    assign o_frac_cnt  = n_fcnt;
    assign o_zone      = n_zone;
    assign o_zone_neg  = n_neg;
    assign o_sticky    = n_sticky;
    assign o_zone_open = (n_ph == PH_TZ_H1) || (n_ph == PH_TZ_H2);

endmodule

FILE: sv/ide_datapath.sv
// ----------------------------------------------------------------------------
// ide_datapath: scanner plus epoch arithmetic pipeline
// Snapshots the parsed fields at the last character and works out the result.
// ----------------------------------------------------------------------------
module ide_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ide_pkg::t_ide_cmd   i_cmd,
    input  ide_pkg::t_in_item   i_item,
    input  logic [1:0]          i_mode,
    input  logic [3:0]          i_prec,
    output ide_pkg::t_ide_sts   o_sts,
    output ide_pkg::t_out_item  o_item
);
    import ide_pkg::*;

    logic [5:0]  len;
    logic [13:0] year;
    logic [6:0]  month, day;
    logic [18:0] hms, zone;
    logic [29:0] frac;
    logic [3:0]  fcnt;
    logic        zneg, zopen;
    logic [2:0]  sticky;

    ide_parse u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(i_cmd.step), .i_clear(i_cmd.clear),
        .i_char(i_item.text_char), .i_mode(i_mode), .i_prec(i_prec),
        .o_len(len), .o_year(year), .o_month(month), .o_day(day), .o_hms(hms),
        .o_frac(frac), .o_frac_cnt(fcnt), .o_zone(zone), .o_zone_neg(zneg),
        .o_sticky(sticky), .o_zone_open(zopen)
    );

    // stage 1: checks and calendar terms
    logic [1:0]         r_mode;
    logic [3:0]         r_prec;
    logic [2:0]         r_err1;
    logic signed [31:0] r_yoff;
    logic signed [31:0] r_dadd;
    logic signed [20:0] r_tsec;
    logic [29:0]        r_frac1, r_pad;

    logic [3:0]  pw;
    logic [13:0] ym1;
    logic        lp;
    logic [2:0]  err1;
    logic [13:0] q4, q100, q400;
    logic signed [20:0] tsec;
    logic [26:0] yr_m, ym1_m;
    logic [7:0]  qy100;
    logic        cent;

    // divide by 100 as a reciprocal multiply, exact for four-digit years
    assign yr_m  = 27'(year) * 27'd5243;
    assign ym1_m = 27'(ym1) * 27'd5243;
    assign qy100 = yr_m[26:19];
    assign cent  = (year == 14'(14'(qy100) * 14'd100));

    assign lp   = (year[1:0] == 2'b00 && !cent) || (cent && qy100[1:0] == 2'b00);
    assign ym1  = year - 14'd1;
    assign q4   = ym1 >> 2;
    assign q100 = {6'd0, ym1_m[26:19]};
    assign q400 = q100 >> 2;
    assign pw   = (fcnt < i_prec) ? 4'(i_prec - fcnt) : 4'd0;
    assign tsec = (len >= 6'd19 ? $signed({2'b0, hms}) : 21'sd0)
                + (zneg ? $signed({2'b0, zone}) : -$signed({2'b0, zone}));

    // error priority
    always_comb begin
        if (len < 6'd10 || sticky[0]) err1 = ERR_DATE;
        else if (month < 7'd1 || month > 7'd12 || day < 7'd1 || day > 7'd31) err1 = ERR_RANGE;
        else if (day > 7'(month_len(month[3:0])) + ((month == 7'd2 && lp) ? 7'd1 : 7'd0))
            err1 = ERR_MONTHEND;
        else if (i_mode == 2'd0) err1 = ERR_OK;
        else if (len >= 6'd19 && sticky[1]) err1 = ERR_TIME;
        else if (sticky[2] || zopen) err1 = ERR_ZONE;
        else err1 = ERR_OK;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_prec  <= i_prec;
            r_err1  <= err1;
            r_yoff  <= 32'sd365 * ($signed({18'd0, year}) - 32'sd1970);
            r_dadd  <= (year == 14'd0 ? 32'sd0 : $signed({18'd0, 14'(14'd1 + q4 - q100 + q400)}))
                     - 32'sd478 + $signed({23'd0, days_before(month[3:0])})
                     + ((month > 7'd2 && lp) ? 32'sd1 : 32'sd0) + $signed({25'd0, day}) - 32'sd1;
            r_tsec  <= tsec;
            r_frac1 <= frac;
            r_pad   <= pow10(pw);
        end
    end

    // stage 2: days, fraction padding
    logic signed [31:0] r_days;
    logic [29:0]        r_frac2, r_scale;
    logic [2:0]         r_err2;
    logic [1:0]         r_mode2;
    logic signed [20:0] r_tsec2;

    always_ff @(posedge i_clk) begin
        r_days  <= r_yoff + r_dadd;
        r_frac2 <= 30'(r_frac1 * r_pad);
        r_scale <= pow10(r_prec);
        r_err2  <= r_err1;
        r_mode2 <= r_mode;
        r_tsec2 <= r_tsec;
    end

    // stage 3: seconds
    logic signed [63:0] r_secs;
    logic signed [31:0] r_days3;
    logic [29:0]        r_frac3, r_scale3;
    logic [2:0]         r_err3;
    logic [1:0]         r_mode3;

    always_ff @(posedge i_clk) begin
        r_secs   <= 64'(r_days) * 64'sd86400 + 64'(r_tsec2);
        r_days3  <= r_days;
        r_frac3  <= r_frac2;
        r_scale3 <= r_scale;
        r_err3   <= r_err2;
        r_mode3  <= r_mode2;
    end

    // stage 4: scaling as partial products (low and high halves)
    logic [63:0] r_plo, r_phi;
    logic signed [63:0] r_secs4;
    logic signed [31:0] r_days4;
    logic [29:0]        r_frac4;
    logic [2:0]         r_err4;
    logic [1:0]         r_mode4;

    always_ff @(posedge i_clk) begin
        r_plo   <= 64'(r_secs[31:0]) * 64'(r_scale3);
        r_phi   <= 64'(r_secs[63:32]) * 64'(r_scale3);
        r_secs4 <= r_secs;
        r_days4 <= r_days3;
        r_frac4 <= r_frac3;
        r_err4  <= r_err3;
        r_mode4 <= r_mode3;
    end

    // stage 5: select result
    logic [63:0] ticks;
    logic [2:0]  err5;
    logic [63:0] val5;

    assign ticks = r_plo + {r_phi[31:0], 32'd0} + 64'(r_frac4);

    always_comb begin
        err5 = r_err4;
        val5 = '0;
        if (r_err4 == ERR_OK) begin
            case (r_mode4)
                2'd0: val5 = 64'(r_days4);
                2'd1: begin
                    if (r_secs4 < 64'sd0 || r_secs4 > 64'sh0FFFFFFFF) err5 = ERR_UINT32;
                    else val5 = r_secs4;
                end
                default: val5 = ticks;
            endcase
        end
        if (err5 != ERR_OK) val5 = '0;
    end

    always_ff @(posedge i_clk) begin
        o_item.epoch_value <= val5;
        o_item.error_code  <= err5;
    end

    // done pulse travels with the pipeline
    logic [4:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_cmd.load};
        end
    end
    assign o_sts.done = r_vld[4];

endmodule

FILE: sv/ide_ctrl.sv
// ----------------------------------------------------------------------------
// ide_ctrl: handshake controller
// Accepts characters, waits for the arithmetic, holds the result until taken.
// ----------------------------------------------------------------------------
module ide_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ide_pkg::t_in_item  i_item,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  ide_pkg::t_ide_sts  i_sts,
    output ide_pkg::t_ide_cmd  o_cmd
);
    import ide_pkg::*;

    typedef enum logic [1:0] { S_SCAN, S_CALC, S_HOLD } t_state;
    t_state r_state;
    logic   r_valid;
    logic   acc;

    assign o_stall = (r_state != S_SCAN);
    assign acc     = i_valid && !o_stall;
    assign o_cmd.step  = acc;
    assign o_cmd.load  = acc && i_item.is_last;
    assign o_cmd.clear = o_cmd.load;
    assign o_valid = r_valid;

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SCAN;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_SCAN: if (o_cmd.load) r_state <= S_CALC;
                S_CALC: if (i_sts.done) begin
                    r_state <= S_HOLD;
                    r_valid <= 1'b1;
                end
                S_HOLD: if (!i_stall) begin
                    r_state <= S_SCAN;
                    r_valid <= 1'b0;
                end
                default: r_state <= S_SCAN;
            endcase
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_HOLD) else $error("valid outside hold");
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_SCAN |-> !o_cmd.step) else $error("accept while busy");
    a_done_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.done |-> r_state == S_CALC) else $error("done outside calc");

endmodule

FILE: sv/iso_datetime_to_epoch_core.sv
// ----------------------------------------------------------------------------
// iso_datetime_to_epoch_core: ISO 8601 text to epoch count
// Top level: config registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage: characters enter on the input channel (i_valid / o_stall), one item
// per cycle while o_stall is low, is_last set on the final character. While
// scanning, one character is taken each cycle. After the last character the
// five-stage epoch arithmetic (calendar terms, days, seconds, 64-bit
// scaling, select) works out the result, which shows on o_valid with o_item;
// input is stalled from the last character until the result is taken.
// The result is held until i_stall is low, after which scanning resumes.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken at any
// edge. Reset sets output mode 1 and 3 fraction digits, clears the scanner
// and drops o_valid. A stalled result stays unchanged.
// ----------------------------------------------------------------------------
module iso_datetime_to_epoch_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ide_pkg::t_in_item  i_item,
    output logic               o_stall,
    output logic               o_valid,
    output ide_pkg::t_out_item o_item,
    input  logic               i_stall,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [3:0]         i_cfg_data
);
    import ide_pkg::*;

    logic [1:0] r_mode;
    logic [3:0] r_digits;
    logic [3:0] prec;
    t_ide_cmd   cmd;
    t_ide_sts   sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd1;
            r_digits <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OUTPUT_MODE:     r_mode   <= i_cfg_data[1:0];
                REG_FRACTION_DIGITS: r_digits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign prec = (r_digits > 4'(MaxFractionDigits)) ? 4'(MaxFractionDigits) : r_digits;

    ide_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_item(i_item),
        .o_stall(o_stall), .o_valid(o_valid), .i_stall(i_stall),
        .i_sts(sts), .o_cmd(cmd)
    );

    ide_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_item(i_item),
        .i_mode(r_mode), .i_prec(prec), .o_sts(sts), .o_item(o_item)
    );

endmodule
